// ===== rtl/core/tws_pkg.sv =====
// Shared types, character codes and helpers of the text word statistics block.
package tws_pkg;

    localparam logic [7:0]  CHAR_TAB     = 8'd9;
    localparam logic [7:0]  CHAR_NEWLINE = 8'd10;
    localparam logic [7:0]  CHAR_SPACE   = 8'd32;
    localparam logic [7:0]  CHAR_PERIOD  = 8'd46;
    localparam logic [7:0]  LEN_SAT      = 8'd255;
    localparam logic [15:0] COUNT_SAT    = 16'hFFFF;

    typedef enum logic [1:0] {
        KIND_SUMMARY  = 2'd0,
        KIND_LONGEST  = 2'd1,
        KIND_SHORTEST = 2'd2
    } kind_t;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       has_byte;
        logic       end_of_text;
    } in_item_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] words;
        logic [15:0] paragraphs;
        logic [7:0]  longest_length;
        logic [7:0]  shortest_length;
        logic [7:0]  word_char;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic [15:0] words;
        logic [15:0] paragraphs;
        logic [7:0]  longest_len;
        logic [7:0]  shortest_len;
    } stats_t;

    function automatic logic [15:0] sat_inc16(input logic [15:0] value, input logic en);
        sat_inc16 = (en && value != COUNT_SAT) ? value + 16'd1 : value;
    endfunction

endpackage

// ===== rtl/core/tws_word_core.sv =====
// Word accumulator: current word, extreme words and counters, updated once per request.
module tws_word_core
    import tws_pkg::*;
#(
    parameter int MAX_WORD_LEN = 31
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             take,
    input  in_item_t                         item,
    output logic                             snap_valid,
    output stats_t                           snap_stats,
    output logic [MAX_WORD_LEN-1:0][7:0]     snap_long_word,
    output logic [MAX_WORD_LEN-1:0][7:0]     snap_short_word
);

    localparam int         IDX_W   = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;
    localparam logic [7:0] MAX_LEN = 8'(MAX_WORD_LEN);

    logic [MAX_WORD_LEN-1:0][7:0] cur_word_reg, cur_word_next;
    logic [MAX_WORD_LEN-1:0][7:0] long_word_reg, long_word_next;
    logic [MAX_WORD_LEN-1:0][7:0] short_word_reg, short_word_next;
    logic [7:0]  cur_len_reg, cur_len_next;
    logic [7:0]  long_len_reg, long_len_next;
    logic [7:0]  short_len_reg, short_len_next;
    logic [15:0] words_reg, words_next;
    logic [15:0] paras_reg, paras_next;
    logic        prev_nl_reg;

    logic       is_word_char;
    logic       is_separator;
    logic       close_word;
    logic       tab_para;
    logic [15:0] paras_tab;

    always_comb begin
        is_word_char = item.has_byte &&
                       (item.byte_in inside {[8'd65:8'd90], [8'd97:8'd122], [8'd48:8'd57]});
        is_separator = item.has_byte &&
                       (item.byte_in inside {CHAR_SPACE, CHAR_PERIOD, CHAR_NEWLINE, CHAR_TAB});

        // Append the character, then close on a separator or at end of text.
        cur_word_next = cur_word_reg;
        if (is_word_char && cur_len_reg < MAX_LEN) begin
            cur_word_next[cur_len_reg[IDX_W-1:0]] = item.byte_in;
        end
        cur_len_next = cur_len_reg;
        if (is_word_char && cur_len_reg != LEN_SAT) begin
            cur_len_next = cur_len_reg + 8'd1;
        end

        close_word = (is_separator || item.end_of_text) && (cur_len_next != 8'd0);

        long_len_next   = long_len_reg;
        long_word_next  = long_word_reg;
        short_len_next  = short_len_reg;
        short_word_next = short_word_reg;
        if (close_word && cur_len_next > long_len_reg) begin
            long_len_next  = cur_len_next;
            long_word_next = cur_word_next;
        end
        if (close_word && cur_len_next < short_len_reg) begin
            short_len_next  = cur_len_next;
            short_word_next = cur_word_next;
        end
        words_next = sat_inc16(words_reg, close_word);
        if (close_word) begin
            cur_len_next = 8'd0;
        end

        tab_para   = item.has_byte && (item.byte_in == CHAR_TAB) && prev_nl_reg;
        paras_tab  = sat_inc16(paras_reg, tab_para);
        paras_next = sat_inc16(paras_tab, item.end_of_text);
    end

    assign snap_valid                 = take && item.end_of_text;
    assign snap_stats.words           = words_next;
    assign snap_stats.paragraphs      = paras_next;
    assign snap_stats.longest_len     = long_len_next;
    assign snap_stats.shortest_len    = short_len_next;
    assign snap_long_word             = long_word_next;
    assign snap_short_word            = short_word_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_len_reg   <= 8'd0;
            long_len_reg  <= 8'd0;
            short_len_reg <= LEN_SAT;
            words_reg     <= 16'd0;
            paras_reg     <= 16'd0;
            prev_nl_reg   <= 1'b0;
        end else if (take) begin
            if (item.end_of_text) begin
                cur_len_reg   <= 8'd0;
                long_len_reg  <= 8'd0;
                short_len_reg <= LEN_SAT;
                words_reg     <= 16'd0;
                paras_reg     <= 16'd0;
                prev_nl_reg   <= 1'b0;
            end else begin
                cur_len_reg   <= cur_len_next;
                long_len_reg  <= long_len_next;
                short_len_reg <= short_len_next;
                words_reg     <= words_next;
                paras_reg     <= paras_next;
                if (item.has_byte) begin
                    prev_nl_reg <= (item.byte_in == CHAR_NEWLINE);
                end
            end
        end
    end

    // Character stores are only read below their length, so they need no reset.
    always_ff @(posedge aclk) begin
        if (take) begin
            cur_word_reg   <= cur_word_next;
            long_word_reg  <= long_word_next;
            short_word_reg <= short_word_next;
        end
    end

endmodule

// ===== rtl/core/tws_report.sv =====
// Report sequencer: holds a snapshot and plays summary and word characters into the output register.
module tws_report
    import tws_pkg::*;
#(
    parameter int MAX_WORD_LEN = 31
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             load,
    input  stats_t                           load_stats,
    input  logic [MAX_WORD_LEN-1:0][7:0]     load_long_word,
    input  logic [MAX_WORD_LEN-1:0][7:0]     load_short_word,
    output logic                             busy,
    output logic                             m_valid,
    input  logic                             m_ready,
    output out_item_t                        m_data
);

    localparam int         IDX_W   = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;
    localparam logic [7:0] MAX_LEN = 8'(MAX_WORD_LEN);

    typedef enum logic [1:0] {
        GEN_IDLE,
        GEN_SUMMARY,
        GEN_LONG,
        GEN_SHORT
    } gen_state_t;

    gen_state_t                   gen_state_reg, gen_state_next;
    logic [IDX_W-1:0]             idx_reg, idx_next;
    logic                         out_valid_reg;
    out_item_t                    out_data_reg;
    stats_t                       stats_reg;
    logic [MAX_WORD_LEN-1:0][7:0] long_word_reg;
    logic [MAX_WORD_LEN-1:0][7:0] short_word_reg;

    logic [7:0] n_long;
    logic [7:0] n_short;
    logic [7:0] idx_inc;
    logic       advance;
    out_item_t  item;

    always_comb begin
        n_long  = (stats_reg.longest_len < MAX_LEN) ? stats_reg.longest_len : MAX_LEN;
        if (stats_reg.shortest_len == LEN_SAT) begin
            n_short = 8'd0;
        end else begin
            n_short = (stats_reg.shortest_len < MAX_LEN) ? stats_reg.shortest_len : MAX_LEN;
        end
        idx_inc = 8'(idx_reg) + 8'd1;

        item           = '0;
        gen_state_next = gen_state_reg;
        idx_next       = idx_reg;
        case (gen_state_reg)
            GEN_SUMMARY: begin
                item.kind            = KIND_SUMMARY;
                item.words           = stats_reg.words;
                item.paragraphs      = stats_reg.paragraphs;
                item.longest_length  = stats_reg.longest_len;
                item.shortest_length = stats_reg.shortest_len;
                item.last            = (n_long == 8'd0) && (n_short == 8'd0);
                idx_next             = '0;
                if (n_long != 8'd0) begin
                    gen_state_next = GEN_LONG;
                end else if (n_short != 8'd0) begin
                    gen_state_next = GEN_SHORT;
                end else begin
                    gen_state_next = GEN_IDLE;
                end
            end
            GEN_LONG: begin
                item.kind      = KIND_LONGEST;
                item.word_char = long_word_reg[idx_reg];
                item.last      = (n_short == 8'd0) && (idx_inc == n_long);
                if (idx_inc == n_long) begin
                    idx_next       = '0;
                    gen_state_next = (n_short != 8'd0) ? GEN_SHORT : GEN_IDLE;
                end else begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            GEN_SHORT: begin
                item.kind      = KIND_SHORTEST;
                item.word_char = short_word_reg[idx_reg];
                item.last      = (idx_inc == n_short);
                if (idx_inc == n_short) begin
                    idx_next       = '0;
                    gen_state_next = GEN_IDLE;
                end else begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            default: begin
                gen_state_next = GEN_IDLE;
            end
        endcase

        advance = (gen_state_reg != GEN_IDLE) && (!out_valid_reg || m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gen_state_reg <= GEN_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end else begin
            if (load) begin
                gen_state_reg <= GEN_SUMMARY;
                idx_reg       <= '0;
            end else if (advance) begin
                gen_state_reg <= gen_state_next;
                idx_reg       <= idx_next;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                out_data_reg  <= item;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            stats_reg      <= load_stats;
            long_word_reg  <= load_long_word;
            short_word_reg <= load_short_word;
        end
    end

    assign busy    = (gen_state_reg != GEN_IDLE);
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

// ===== rtl/core/text_word_statistics.sv =====
// Report: when the end-of-text request is taken, the snapshot is loaded, and the summary then
// enters the output register once free; the remaining results follow one per accepted cycle.
// A report runs 1 + min(longest, MAX_WORD_LEN) + min(shortest, MAX_WORD_LEN) results, where
// the shortest term is zero when the text holds no word.
// Throughput: one text byte per cycle; an end-of-text request waits only while the report
// sequencer of the previous text is still handing results to the output register.
// Reset: aresetn is synchronous and active low; it clears counters, lengths and the sequencer,
// and the character stores are left as they are.
module text_word_statistics
    import tws_pkg::*;
#(
    parameter int MAX_WORD_LEN = 31
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    // The snapshot travelling from the word accumulator into the report sequencer.
    logic                         snap_valid;
    stats_t                       snap_stats;
    logic [MAX_WORD_LEN-1:0][7:0] snap_long_word;
    logic [MAX_WORD_LEN-1:0][7:0] snap_short_word;
    logic                         report_busy;
    logic                         take;

    // Ordinary bytes are always taken. A request that ends the text needs the
    // snapshot registers, so it is held back while an earlier report is still
    // being sequenced. The last result of that report may still sit in the
    // output register, which lets the next report start straight behind it.
    assign s_ready = !report_busy || !s_data.end_of_text;
    assign take    = s_valid && s_ready;

    // Classification, word assembly, the parallel copy into the longest and
    // shortest stores and the saturating counters are all combinational logic.
    tws_word_core #(
        .MAX_WORD_LEN (MAX_WORD_LEN)
    ) u_word_core (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .take            (take),
        .item            (s_data),
        .snap_valid      (snap_valid),
        .snap_stats      (snap_stats),
        .snap_long_word  (snap_long_word),
        .snap_short_word (snap_short_word)
    );

    // The sequencer copies the closed statistics of a text and emits them one
    // result per cycle, when not stalled by the receiver, through a registered output.
    tws_report #(
        .MAX_WORD_LEN (MAX_WORD_LEN)
    ) u_report (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .load            (snap_valid),
        .load_stats      (snap_stats),
        .load_long_word  (snap_long_word),
        .load_short_word (snap_short_word),
        .busy            (report_busy),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data)
    );

endmodule

// ===== rtl/core/tws_checker.sv =====
// Port-level checks of the text word statistics block and their binding to the top level.
module tws_checker
    import tws_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input in_item_t  s_data,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

    // A request that does not end the text is never held back.
    a_bytes_taken: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_data.end_of_text |-> s_ready)
        else $error("request that does not end the text was refused");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // A summary that is not last is followed by characters, never by another summary.
    a_no_early_summary: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_data.kind == KIND_SUMMARY && !m_data.last
        |=> !(m_valid && m_data.kind == KIND_SUMMARY))
        else $error("summary followed a summary that was not last");

    // Shortest-word characters are never followed by longest-word characters.
    a_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_data.kind == KIND_SHORTEST && !m_data.last
        |=> !(m_valid && m_data.kind == KIND_LONGEST))
        else $error("longest word character after shortest word character");

    // A stored shortest word implies a longest word at least as long and a nonzero word count.
    a_lengths: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.kind == KIND_SUMMARY && m_data.shortest_length != LEN_SAT
        |-> m_data.longest_length != 8'd0 && m_data.shortest_length <= m_data.longest_length
            && m_data.words != 16'd0)
        else $error("inconsistent word lengths in summary");

endmodule

bind text_word_statistics tws_checker u_tws_checker (.*);

// ===== tb/testbench.sv =====
// Self-checking testbench for the text word statistics block.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tws_pkg::*;

    // The block stores at most this many characters of any one word.
    localparam int STORE_DEPTH = 31;
    // Minimum number of counted text requests in the random part.
    localparam int RANDOM_REQUESTS = 100;
    // Only the first ten mismatches are printed; later ones are just counted.
    localparam int REPORT_LIMIT = 10;

    logic      aclk = 1'b0;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_data;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    text_word_statistics #(
        .MAX_WORD_LEN(STORE_DEPTH)
    ) DUT (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    // 10 ns clock. Inputs are driven on the falling edge so that they are settled
    // well before the rising edge at which both the block and the checker sample them.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predicted state of the block. It mirrors what the hardware must hold
    // between requests: the word being assembled, the longest and shortest
    // words seen so far and the two saturating counters.
    // ------------------------------------------------------------------
    logic [7:0]  cur_chars   [STORE_DEPTH];
    logic [7:0]  long_chars  [STORE_DEPTH];
    logic [7:0]  short_chars [STORE_DEPTH];
    logic [7:0]  cur_len;
    logic [7:0]  long_len;
    logic [7:0]  short_len;
    logic [15:0] word_count;
    logic [15:0] para_count;
    logic        after_newline;

    // Report results still owed by the block, oldest first.
    out_item_t pending_report[$];
    int        mismatch_count = 0;

    // Sender burst state: the number of requests left in the current burst.
    int burst_left = 0;

    // Receiver stall pattern: an 8-bit mask replayed until the 6-bit phase wraps, then replaced.
    logic [7:0] stall_mask  = 8'hFF;
    logic [5:0] stall_phase = '0;

    function automatic bit is_letter_or_digit(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || (c >= "0" && c <= "9");
    endfunction

    function automatic bit ends_word(input logic [7:0] c);
        return c == CHAR_SPACE || c == CHAR_PERIOD || c == CHAR_NEWLINE || c == CHAR_TAB;
    endfunction

    // Back to the start of a fresh text. The character stores are left alone,
    // since only entries below the matching length are ever read.
    function automatic void reset_text_state();
        cur_len       = '0;
        long_len      = '0;
        short_len     = LEN_SAT;
        word_count    = '0;
        para_count    = '0;
        after_newline = 1'b0;
    endfunction

    // A non-empty word is counted and may replace either extreme. Strict
    // comparisons mean the earliest word wins a tie, and a word whose length
    // has saturated at 255 can never become the shortest one.
    function automatic void close_pending_word();
        if (cur_len == 0)
            return;
        if (cur_len > long_len) begin
            long_len   = cur_len;
            long_chars = cur_chars;
        end
        if (cur_len < short_len) begin
            short_len   = cur_len;
            short_chars = cur_chars;
        end
        if (word_count != COUNT_SAT)
            word_count++;
        cur_len = '0;
    endfunction

    // Updates the predicted state with one accepted request and, at the end of
    // a text, queues the whole report that the block must produce.
    function automatic void predict_statistics(input in_item_t req);
        out_item_t res;
        int        n_long;
        int        n_short;
        if (req.has_byte) begin
            if (is_letter_or_digit(req.byte_in)) begin
                if (cur_len < STORE_DEPTH)
                    cur_chars[cur_len] = req.byte_in;
                if (cur_len != LEN_SAT)
                    cur_len++;
            end else if (ends_word(req.byte_in)) begin
                close_pending_word();
            end
            // A tab straight after a newline marks a new paragraph; any other
            // byte in between, even an ignored one, breaks the pair.
            if (req.byte_in == CHAR_TAB && after_newline && para_count != COUNT_SAT)
                para_count++;
            after_newline = (req.byte_in == CHAR_NEWLINE);
        end
        if (!req.end_of_text)
            return;

        close_pending_word();
        if (para_count != COUNT_SAT)
            para_count++;

        n_long  = (long_len < STORE_DEPTH) ? int'(long_len) : STORE_DEPTH;
        n_short = (short_len == LEN_SAT) ? 0 :
                  (short_len < STORE_DEPTH) ? int'(short_len) : STORE_DEPTH;

        res                 = '0;
        res.kind            = KIND_SUMMARY;
        res.words           = word_count;
        res.paragraphs      = para_count;
        res.longest_length  = long_len;
        res.shortest_length = short_len;
        res.last            = (n_long + n_short == 0);
        pending_report.push_back(res);

        for (int i = 0; i < n_long; i++) begin
            res           = '0;
            res.kind      = KIND_LONGEST;
            res.word_char = long_chars[i];
            res.last      = (n_short == 0 && i == n_long - 1);
            pending_report.push_back(res);
        end
        for (int i = 0; i < n_short; i++) begin
            res           = '0;
            res.kind      = KIND_SHORTEST;
            res.word_char = short_chars[i];
            res.last      = (i == n_short - 1);
            pending_report.push_back(res);
        end
        reset_text_state();
    endfunction

    function automatic string describe(input out_item_t r);
        return {$sformatf("kind=%0d words=%0d paragraphs=%0d ",
                          r.kind, r.words, r.paragraphs),
                $sformatf("longest=%0d shortest=%0d char=%02h last=%0b",
                          r.longest_length, r.shortest_length, r.word_char, r.last)};
    endfunction

    function automatic void note_mismatch(input string what, input string want, input string got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("%0t ns: %s\n    expected %s\n    actual   %s", $time, what, want, got);
    endfunction

    // Checking process. On every rising edge it first compares a taken result
    // with the oldest prediction, then feeds a taken request to the predictor.
    // A result can never stem from a request taken at the same edge, so this
    // order is safe, and doing both in one process keeps it deterministic.
    always @(posedge aclk) begin : result_check
        out_item_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (pending_report.size() == 0) begin
                    note_mismatch("result with nothing expected", "none", describe(m_data));
                end else begin
                    want = pending_report.pop_front();
                    if (m_data.kind !== want.kind || m_data.words !== want.words ||
                        m_data.paragraphs !== want.paragraphs ||
                        m_data.longest_length !== want.longest_length ||
                        m_data.shortest_length !== want.shortest_length ||
                        m_data.word_char !== want.word_char || m_data.last !== want.last)
                        note_mismatch("report result differs", describe(want), describe(m_data));
                end
            end
            if (s_valid && s_ready)
                predict_statistics(s_data);
        end
    end

    // Receiver back-pressure. Roughly a quarter of the masks are all ones,
    // giving stretches with no stalls; the others stall in a repeating pattern
    // that always leaves at least one ready cycle in eight.
    always @(negedge aclk) begin
        if (stall_phase == 0)
            stall_mask = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom_range(1, 255));
        m_ready = stall_mask[stall_phase[2:0]];
        stall_phase++;
    end

    function automatic in_item_t text_request(input logic [7:0] b, input logic has,
                                              input logic eot);
        in_item_t req;
        req.byte_in     = b;
        req.has_byte    = has;
        req.end_of_text = eot;
        return req;
    endfunction

    function automatic logic [7:0] random_word_char();
        case ($urandom_range(0, 2))
            0:       return 8'("A" + $urandom_range(0, 25));
            1:       return 8'("a" + $urandom_range(0, 25));
            default: return 8'("0" + $urandom_range(0, 9));
        endcase
    endfunction

    // Offers one request and returns once it has been taken. Requests go out in
    // bursts; between bursts the valid line drops for a random number of cycles.
    // Valid is never lowered and raised at the same falling edge.
    task automatic send_request(input in_item_t req);
        int gap;
        if (burst_left == 0) begin
            gap        = $urandom_range(0, 8);
            burst_left = $urandom_range(1, 24);
            repeat (gap) begin
                @(negedge aclk);
                s_valid = 1'b0;
            end
        end
        burst_left--;
        @(negedge aclk);
        s_valid = 1'b1;
        s_data  = req;
        do
            @(posedge aclk);
        while (!s_ready);
    endtask

    task automatic send_string(input string text);
        for (int i = 0; i < text.len(); i++)
            send_request(text_request(text[i], 1'b1, 1'b0));
    endtask

    task automatic send_random_word(input int length);
        repeat (length)
            send_request(text_request(random_word_char(), 1'b1, 1'b0));
    endtask

    // Texts with no words at all: a bare end marker, then a text of ignored
    // bytes only (byte 255 among them) closed by an ignored byte. The grave
    // accent, just below the lower-case letters, goes out as a plain code.
    task automatic test_empty_texts();
        send_request(text_request(8'h00, 1'b0, 1'b1));
        send_string("!@[");
        send_request(text_request(8'h60, 1'b1, 1'b0));
        send_string("{/:");
        send_request(text_request(LEN_SAT, 1'b1, 1'b0));
        send_request(text_request(LEN_SAT, 1'b1, 1'b1));
    endtask

    // The edges of the letter and digit ranges, the neighbour @ of A, all four
    // separators, ties on length, and a word still open when the text ends.
    task automatic test_words_and_ties();
        send_string("Az 09 Za.\tmid\nZ9 a@z\n");
        send_request(text_request("q", 1'b1, 1'b1));
    endtask

    // Paragraph marks: a newline then a tab counts, an ignored byte between
    // them breaks the pair, an idle step between them does not, a tab then a
    // newline does not count, and a text may end on the tab of a pair.
    task automatic test_paragraphs();
        send_string("a\n");
        send_request(text_request(8'hA5, 1'b0, 1'b0));
        send_string("\tb\n!\tc\t\nd\n\n\te\n");
        send_request(text_request(CHAR_TAB, 1'b1, 1'b1));
    endtask

    // Words at and beyond the store depth, and a word whose length saturates.
    task automatic test_long_words();
        send_random_word(STORE_DEPTH);
        send_string(" ");
        send_random_word(STORE_DEPTH + 1);
        send_string(".ab");
        send_request(text_request(8'h00, 1'b0, 1'b1));

        // A lone saturated word is the longest but can never be the shortest.
        send_random_word(260);
        send_request(text_request(CHAR_SPACE, 1'b1, 1'b1));
    endtask

    // Random texts: mostly well-formed words with random separators, salted
    // with paragraph pairs, arbitrary bytes and idle steps, and closed in one
    // of three ways. Idle steps do not count towards the request total.
    task automatic test_random_texts();
        int          sent;
        int          n_words;
        int          pick;
        logic [7:0]  sep_codes [4];
        sent      = 0;
        sep_codes = '{CHAR_SPACE, CHAR_PERIOD, CHAR_NEWLINE, CHAR_TAB};
        while (sent < RANDOM_REQUESTS) begin
            n_words = $urandom_range(0, 12);
            for (int w = 0; w < n_words; w++) begin
                pick = $urandom_range(0, 99);
                if (pick < 80) begin
                    pick = $urandom_range(1, 8);
                end else if (pick < 95) begin
                    pick = $urandom_range(9, 40);
                end else begin
                    pick = 0;
                end
                send_random_word(pick);
                sent += pick;

                pick = $urandom_range(0, 99);
                if (pick < 10) begin
                    send_request(text_request(8'($urandom_range(0, 255)), 1'b1, 1'b0));
                    sent++;
                end else if (pick < 16) begin
                    send_request(text_request(8'($urandom_range(0, 255)), 1'b0, 1'b0));
                end else if (pick < 30) begin
                    send_string("\n\t");
                    sent += 2;
                end
                send_request(text_request(sep_codes[$urandom_range(0, 3)], 1'b1, 1'b0));
                sent++;
            end

            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                send_request(text_request(8'($urandom_range(0, 255)), 1'b0, 1'b1));
            end else if (pick < 70) begin
                send_request(text_request(random_word_char(), 1'b1, 1'b1));
            end else begin
                send_request(text_request(8'($urandom_range(0, 255)), 1'b1, 1'b1));
            end
            sent++;
        end
    endtask

    initial begin : stimulus
        int waited;
        s_valid = 1'b0;
        s_data  = '0;
        aresetn = 1'b0;
        reset_text_state();
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_empty_texts();
        test_words_and_ties();
        test_paragraphs();
        test_long_words();
        test_random_texts();

        @(negedge aclk);
        s_valid = 1'b0;

        // Let the last report drain, then watch a little longer for strays.
        waited = 0;
        while (pending_report.size() != 0 && waited < 100000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (20) @(posedge aclk);

        if (pending_report.size() != 0)
            $display("%0d expected report results never arrived", pending_report.size());

        if (mismatch_count == 0 && pending_report.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Hard stop far beyond the slowest correct run, even with the longest stalls on every report.
    initial begin
        #20_000_000;
        $display("Timeout: the run did not complete");
        $display("*** FAILED ***");
        $finish;
    end

endmodule
